// ===== hdl/tsdr_pkg.sv =====
// Package: shared constants, command and status types for the delayed sample renormaliser.
package tsdr_pkg;
  localparam int DEPTH_DEF = 32;
  localparam int CFG_W = 20;
  localparam logic [CFG_W-1:0] KEEP_RESET = 20'd10000;
  localparam logic CFG_DELAY = 1'b0;
  localparam logic CFG_KEEP = 1'b1;
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic load;
    logic write;
    logic evict_rd;
    logic evict_pop;
    logic search_rd;
    logic search_step;
    logic norm_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic empty;
    logic evict_hit;
    logic search_hit;
    logic search_last;
    logic norm_done;
  } sts_t;
endpackage

// ===== hdl/timed_sample_delay_renorm.sv =====
// Top level: delayed sensor sample store with quaternion renormalisation.
// Store transfer: sample written, expired entries evicted; input stalled meanwhile.
// Tick transfer: entries searched from the newest back, the first hit normalised (31 root
// steps, four 44-step divisions), a zero quaternion unchanged; result held until taken.
// One item in flight at a time. Synchronous active-low reset empties the store
// and restores delay 0 and keep window 10000 us; memory contents stay undefined.
module timed_sample_delay_renorm #(
  parameter int DEPTH = tsdr_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [tsdr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_time_now,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_rate_x,
  output logic signed [15:0] out_rate_y,
  output logic signed [15:0] out_rate_z
);
  logic [tsdr_pkg::CFG_W-1:0] delay_r, keep_r;
  tsdr_pkg::cmd_t cmd;
  tsdr_pkg::sts_t sts;
  logic [63:0] oq;
  logic [47:0] orate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      keep_r <= tsdr_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tsdr_pkg::CFG_DELAY) delay_r <= cfg_wdata;
      else keep_r <= cfg_wdata;
    end
  end

  tsdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsdr_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .delay_us    (delay_r),
    .keep_us     (keep_r),
    .in_action   (in_action),
    .in_time_now (in_time_now),
    .in_quat     ({in_quat_z, in_quat_y, in_quat_x, in_quat_w}),
    .in_rate     ({in_rate_z, in_rate_y, in_rate_x}),
    .out_quat    (oq),
    .out_rate    (orate)
  );

  assign out_w = oq[15:0];
  assign out_x = oq[31:16];
  assign out_y = oq[47:32];
  assign out_z = oq[63:48];
  assign out_rate_x = orate[15:0];
  assign out_rate_y = orate[31:16];
  assign out_rate_z = orate[47:32];
endmodule

// ===== hdl/tsdr_ctrl.sv =====
// Controller: sequences store, eviction, backward search, normalisation and output transfer.
module tsdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tsdr_pkg::sts_t     sts,
  output tsdr_pkg::cmd_t     cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_WR    = 10'b0000000100,
    S_EVRD  = 10'b0000001000,
    S_EVCHK = 10'b0000010000,
    S_SRD   = 10'b0000100000,
    S_SCHK  = 10'b0001000000,
    S_NORM  = 10'b0010000000,
    S_NWAIT = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (sts.is_tick) begin
          if (sts.empty) state_nxt = S_IDLE;
          else begin
            cmd.search_rd = 1'b1;
            state_nxt = S_SCHK;
          end
        end else state_nxt = S_WR;
      end
      S_WR: begin
        cmd.write = 1'b1;
        state_nxt = S_EVRD;
      end
      S_EVRD: begin
        cmd.evict_rd = 1'b1;
        state_nxt = S_EVCHK;
      end
      S_EVCHK: begin
        if (sts.evict_hit) begin
          cmd.evict_pop = 1'b1;
          state_nxt = S_EVRD;
        end else state_nxt = S_IDLE;
      end
      S_SRD: begin
        cmd.search_rd = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (sts.search_hit) state_nxt = S_NORM;
        else if (sts.search_last) state_nxt = S_IDLE;
        else begin
          cmd.search_step = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_NORM: begin
        cmd.norm_start = 1'b1;
        state_nxt = S_NWAIT;
      end
      S_NWAIT: if (sts.norm_done) begin
        cmd.out_load = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/tsdr_norm.sv =====
// Normaliser: bit-serial square root and restoring divisions with rounding and saturation.
module tsdr_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         quat,
  output logic                done,
  output logic [63:0]         result
);
  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_SUM  = 5'b00010,
    N_SQRT = 5'b00100,
    N_DIV  = 5'b01000,
    N_FIN  = 5'b10000
  } nstate_t;

  nstate_t st_r, st_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [32:0] s_r, s_nxt;
  logic [61:0] rad_r, rad_nxt;
  logic [32:0] root_r, root_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [43:0] num_r, num_nxt;
  logic [32:0] drem_r, drem_nxt;
  logic [44:0] quo_r, quo_nxt;
  logic [63:0] res_r, res_nxt;

  logic signed [15:0] qc;
  logic [15:0] mag;
  logic [1:0]  comp_inc;
  logic signed [15:0] qn;
  logic [15:0] magn;
  logic [34:0] trial;
  logic [34:0] rem_sh;
  logic [33:0] dsh;
  logic [45:0] qr;
  logic [15:0] sat;

  always_comb begin
    qc = $signed(quat[16*comp_r +: 16]);
    mag = qc[15] ? 16'(-qc) : 16'(qc);
    comp_inc = comp_r + 2'd1;
    qn = $signed(quat[16*comp_inc +: 16]);
    magn = qn[15] ? 16'(-qn) : 16'(qn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= N_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    comp_r <= comp_nxt;
    cnt_r <= cnt_nxt;
    sq_r <= sq_nxt;
    s_r <= s_nxt;
    rad_r <= rad_nxt;
    root_r <= root_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    drem_r <= drem_nxt;
    quo_r <= quo_nxt;
    res_r <= res_nxt;
  end

  assign done = (st_r == N_FIN);
  assign result = res_r;

  always_comb begin
    st_nxt = st_r;
    comp_nxt = comp_r;
    cnt_nxt = cnt_r;
    sq_nxt = sq_r;
    s_nxt = s_r;
    rad_nxt = rad_r;
    root_nxt = root_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    drem_nxt = drem_r;
    quo_nxt = quo_r;
    res_nxt = res_r;
    rem_sh = {rem_r[32:0], rad_r[61:60]};
    trial = {root_r[32:0], 2'b01};
    dsh = {drem_r, num_r[43]};
    qr = '0;
    sat = '0;
    unique case (st_r)
      N_IDLE: if (start) begin
        comp_nxt = 2'd0;
        cnt_nxt = 6'd0;
        s_nxt = '0;
        st_nxt = N_SUM;
      end
      N_SUM: begin
        // one square per cycle, added to the sum in the next cycle
        sq_nxt = 32'(mag) * 32'(mag);
        if (cnt_r != 6'd0) s_nxt = s_r + 33'(sq_r);
        cnt_nxt = cnt_r + 6'd1;
        comp_nxt = comp_r + 2'd1;
        if (cnt_r == 6'd4) begin
          if (s_r + 33'(sq_r) == 33'd0) begin
            res_nxt = quat;
            st_nxt = N_FIN;
          end else begin
            rad_nxt = {1'b0, s_r[32:0] + 33'(sq_r), 28'd0};
            root_nxt = '0;
            rem_nxt = '0;
            cnt_nxt = 6'd0;
            comp_nxt = 2'd0;
            st_nxt = N_SQRT;
          end
        end
      end
      N_SQRT: begin
        rad_nxt = {rad_r[59:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          root_nxt = {root_r[31:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          root_nxt = {root_r[31:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd30) begin
          cnt_nxt = 6'd0;
          comp_nxt = 2'd0;
          num_nxt = {mag, 28'd0};
          drem_nxt = '0;
          quo_nxt = '0;
          st_nxt = N_DIV;
        end
      end
      N_DIV: begin
        num_nxt = {num_r[42:0], 1'b0};
        if (dsh >= {1'b0, root_r}) begin
          drem_nxt = 33'(dsh - {1'b0, root_r});
          quo_nxt = {quo_r[43:0], 1'b1};
        end else begin
          drem_nxt = dsh[32:0];
          quo_nxt = {quo_r[43:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd43) begin
          qr = {1'b0, quo_nxt} + 46'({drem_nxt, 1'b0} >= {1'b0, root_r});
          if (qc[15]) sat = (qr > 46'd32768) ? 16'h8000 : 16'(-qr[15:0]);
          else sat = (qr > 46'd32767) ? 16'h7FFF : qr[15:0];
          res_nxt[16*comp_r +: 16] = sat;
          cnt_nxt = 6'd0;
          drem_nxt = '0;
          quo_nxt = '0;
          comp_nxt = comp_inc;
          if (comp_r == 2'd3) st_nxt = N_FIN;
          else num_nxt = {magn, 28'd0};
        end
      end
      N_FIN: st_nxt = N_IDLE;
      default: st_nxt = N_IDLE;
    endcase
  end
endmodule

// ===== hdl/tsdr_dp.sv =====
// Datapath: sample memories, circular pointers, age compares and output register.
module tsdr_dp #(
  parameter int DEPTH = tsdr_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsdr_pkg::cmd_t     cmd,
  output tsdr_pkg::sts_t     sts,
  input  logic [tsdr_pkg::CFG_W-1:0] delay_us,
  input  logic [tsdr_pkg::CFG_W-1:0] keep_us,
  input  logic               in_action,
  input  logic [31:0]        in_time_now,
  input  logic [63:0]        in_quat,
  input  logic [47:0]        in_rate,
  output logic [63:0]        out_quat,
  output logic [47:0]        out_rate
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]  stamp_mem [DEPTH];
  logic [63:0]  quat_mem [DEPTH];
  logic [47:0]  rate_mem [DEPTH];

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          act_r;
  logic [31:0]   now_r;
  logic [63:0]   q_r;
  logic [47:0]   r_r;
  logic [31:0]   rd_stamp_r;
  logic [63:0]   rd_quat_r;
  logic [47:0]   rd_rate_r;
  logic [63:0]   oq_r;
  logic [47:0]   or_r;
  logic [63:0]   nres;
  logic          ndone;

  logic [AW-1:0] wr_slot, rd_slot, old_adv;
  logic [31:0]   age;
  logic [CW-1:0] fill_pre;
  logic [AW-1:0] old_pre;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] d;
    d = v - (CW+1)'(DEPTH);
    return (v >= (CW+1)'(DEPTH)) ? d[AW-1:0] : v[AW-1:0];
  endfunction

  assign old_adv = wrap((CW+1)'(oldest_r) + (CW+1)'(1));
  assign old_pre = (fill_r == CW'(DEPTH)) ? old_adv : oldest_r;
  assign fill_pre = (fill_r == CW'(DEPTH)) ? CW'(DEPTH - 1) : fill_r;
  assign wr_slot = wrap((CW+1)'(old_pre) + (CW+1)'(fill_pre));
  assign rd_slot = cmd.evict_rd ? oldest_r
                 : wrap((CW+1)'(oldest_r) + (CW+1)'(k_r) - (CW+1)'(1));
  assign age = now_r - rd_stamp_r;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      stamp_mem[wr_slot] <= now_r;
      quat_mem[wr_slot] <= q_r;
      rate_mem[wr_slot] <= r_r;
    end
    if (cmd.evict_rd || cmd.search_rd) begin
      rd_stamp_r <= stamp_mem[rd_slot];
      rd_quat_r <= quat_mem[rd_slot];
      rd_rate_r <= rate_mem[rd_slot];
    end
  end

  always_comb begin
    oldest_nxt = oldest_r;
    fill_nxt = fill_r;
    k_nxt = k_r;
    if (cmd.write) begin
      oldest_nxt = old_pre;
      fill_nxt = fill_pre + CW'(1);
    end
    if (cmd.evict_pop) begin
      oldest_nxt = old_adv;
      fill_nxt = fill_r - CW'(1);
    end
    if (cmd.load) k_nxt = fill_r;
    if (cmd.search_step) k_nxt = k_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      fill_r <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.load) begin
      act_r <= in_action;
      now_r <= in_time_now;
      q_r <= in_quat;
      r_r <= in_rate;
    end
    if (cmd.out_load) begin
      oq_r <= nres;
      or_r <= rd_rate_r;
    end
  end

  tsdr_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.norm_start),
    .quat   (rd_quat_r),
    .done   (ndone),
    .result (nres)
  );

  always_comb begin
    sts.is_tick = (act_r == tsdr_pkg::ACT_TICK);
    sts.empty = (fill_r == '0);
    sts.evict_hit = (fill_r != '0) && (age > 32'(keep_us));
    sts.search_hit = (age >= 32'(delay_us));
    sts.search_last = (k_r == CW'(1));
    sts.norm_done = ndone;
  end

  assign out_quat = oq_r;
  assign out_rate = or_r;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for timed_sample_delay_renorm: random and directed transfers checked against a mirror.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic action;
    logic [31:0] stamp;
    logic signed [15:0] qw, qx, qy, qz, rx, ry, rz;
    bit drain;
  } sample_item_t;

  typedef struct {
    logic signed [15:0] w, x, y, z, rx, ry, rz;
  } attitude_t;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [tsdr_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_action;
  logic [31:0] in_time_now;
  logic signed [15:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic signed [15:0] in_rate_x, in_rate_y, in_rate_z;
  logic out_valid, out_stall;
  logic signed [15:0] out_w, out_x, out_y, out_z, out_rate_x, out_rate_y, out_rate_z;

  timed_sample_delay_renorm dut (.*);

  // mirror of the sample store
  logic [31:0] mir_stamp [32];
  logic signed [15:0] mir_quat [32][4];
  logic signed [15:0] mir_rate [32][3];
  int unsigned mir_oldest, mir_fill;
  logic [19:0] mir_delay, mir_keep;

  sample_item_t pending_items[$];
  attitude_t delayed_samples[$];
  sample_item_t cur;
  int gap_left, rx_gap_left, accepted_cnt, rx_hold_left, mismatches;
  bit quiet, hold_done;
  logic [31:0] clock_us;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] renorm_comp(logic signed [15:0] q,
                                                     longint unsigned n);
    longint unsigned mag, quo, rem;
    longint r;
    mag = (q < 0) ? longint'(-int'(q)) : longint'(q);
    quo = (mag << 28) / n;
    rem = (mag << 28) % n;
    if (rem * 2 >= n) quo++;
    r = (q < 0) ? -longint'(quo) : longint'(quo);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_delayed_sample(sample_item_t it);
    int unsigned slot, k;
    longint unsigned s, n;
    attitude_t a;
    if (it.action == tsdr_pkg::ACT_STORE) begin
      if (mir_fill >= 32) begin
        mir_oldest = (mir_oldest + 1) % 32;
        mir_fill = 31;
      end
      slot = (mir_oldest + mir_fill) % 32;
      mir_stamp[slot] = it.stamp;
      mir_quat[slot] = '{it.qw, it.qx, it.qy, it.qz};
      mir_rate[slot] = '{it.rx, it.ry, it.rz};
      mir_fill++;
      while (mir_fill > 0 && 32'(it.stamp - mir_stamp[mir_oldest]) > {12'd0, mir_keep}) begin
        mir_oldest = (mir_oldest + 1) % 32;
        mir_fill--;
      end
      return;
    end
    for (k = mir_fill; k > 0; k--) begin
      slot = (mir_oldest + k - 1) % 32;
      if (32'(it.stamp - mir_stamp[slot]) >= {12'd0, mir_delay}) begin
        s = 0;
        for (int j = 0; j < 4; j++)
          s += longint'(mir_quat[slot][j]) * longint'(mir_quat[slot][j]);
        if (s == 0) begin
          a.w = mir_quat[slot][0]; a.x = mir_quat[slot][1];
          a.y = mir_quat[slot][2]; a.z = mir_quat[slot][3];
        end else begin
          n = isqrt(s << 28);
          a.w = renorm_comp(mir_quat[slot][0], n);
          a.x = renorm_comp(mir_quat[slot][1], n);
          a.y = renorm_comp(mir_quat[slot][2], n);
          a.z = renorm_comp(mir_quat[slot][3], n);
        end
        a.rx = mir_rate[slot][0]; a.ry = mir_rate[slot][1]; a.rz = mir_rate[slot][2];
        delayed_samples.insert(delayed_samples.size(), a);
        return;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom % 100;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_delayed_sample(cur);
        accepted_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && delayed_samples.size() > 0)) begin
          cur = pending_items[0];
          pending_items.delete(0);
          in_action <= cur.action;
          in_time_now <= cur.stamp;
          in_quat_w <= cur.qw; in_quat_x <= cur.qx;
          in_quat_y <= cur.qy; in_quat_z <= cur.qz;
          in_rate_x <= cur.rx; in_rate_y <= cur.ry; in_rate_z <= cur.rz;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold, started once enough transfers have gone in
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 700) begin
      rx_hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    attitude_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (delayed_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          e = delayed_samples[0];
          delayed_samples.delete(0);
          if (e.w !== out_w || e.x !== out_x || e.y !== out_y || e.z !== out_z ||
              e.rx !== out_rate_x || e.ry !== out_rate_y || e.rz !== out_rate_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d / %0d %0d %0d got %0d %0d %0d %0d / %0d %0d %0d",
                       e.w, e.x, e.y, e.z, e.rx, e.ry, e.rz,
                       out_w, out_x, out_y, out_z, out_rate_x, out_rate_y, out_rate_z);
          end
        end
      end
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        out_stall <= 1'b1;
      end else begin
        rx_gap_left = pick_gap();
        out_stall <= (rx_gap_left > 0);
      end
    end
  end

  task automatic write_reg(logic idx, logic [tsdr_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tsdr_pkg::CFG_DELAY) mir_delay = val;
    else mir_keep = val;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || delayed_samples.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    unique case ($urandom % 8)
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(logic act, logic [31:0] t, logic signed [15:0] w, x, y, z,
                          bit drain = 0);
    sample_item_t it;
    it.action = act; it.stamp = t;
    it.qw = w; it.qx = x; it.qy = y; it.qz = z;
    it.rx = 16'($urandom); it.ry = 16'($urandom); it.rz = 16'($urandom);
    it.drain = drain;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic random_phase(int count, int dt_max);
    int r;
    bit zero_q;
    for (int i = 0; i < count; i++) begin
      r = $urandom % 100;
      if (r < 2) clock_us -= $urandom_range(1, 5000);
      else if (r < 5) clock_us += $urandom_range(0, 2000000);
      else clock_us += $urandom_range(0, dt_max);
      zero_q = ($urandom % 20) == 0;
      add_item(($urandom % 100) < 45, clock_us,
               zero_q ? 16'sd0 : rand_comp(), zero_q ? 16'sd0 : rand_comp(),
               zero_q ? 16'sd0 : rand_comp(), zero_q ? 16'sd0 : rand_comp(),
               (i % 100) == 99);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; in_action = 1'b0; in_time_now = '0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    in_rate_x = '0; in_rate_y = '0; in_rate_z = '0;
    out_stall = 1'b0;
    mismatches = 0; accepted_cnt = 0; quiet = 0;
    mir_oldest = 0; mir_fill = 0; mir_delay = '0; mir_keep = tsdr_pkg::KEEP_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tick, extremes, zero quaternion, wrap, future stamp
    add_item(tsdr_pkg::ACT_TICK, 32'd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
    add_item(tsdr_pkg::ACT_STORE, 32'd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    add_item(tsdr_pkg::ACT_TICK, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_STORE, 32'd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_TICK, 32'd10, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    add_item(tsdr_pkg::ACT_STORE, 32'd20, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    add_item(tsdr_pkg::ACT_TICK, 32'd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_STORE, 32'd30, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_STORE, 32'd40, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
    add_item(tsdr_pkg::ACT_TICK, 32'd40, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_STORE, 32'd20000, 16'sd100, 16'sd200, -16'sd300, 16'sd5);
    add_item(tsdr_pkg::ACT_TICK, 32'd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_STORE, 32'hFFFF_FFFF, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
    add_item(tsdr_pkg::ACT_TICK, 32'd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_STORE, 32'd1000, 16'sd7, -16'sd7, 16'sd7, -16'sd7);
    add_item(tsdr_pkg::ACT_STORE, 32'd500, 16'sd3, 16'sd0, -16'sd4, 16'sd0);
    add_item(tsdr_pkg::ACT_TICK, 32'd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_item(tsdr_pkg::ACT_TICK, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
    wait_idle();

    write_reg(tsdr_pkg::CFG_DELAY, 20'd500);
    write_reg(tsdr_pkg::CFG_KEEP, 20'd20000);
    clock_us = 32'd100;
    random_phase(250, 400);
    wait_idle();

    write_reg(tsdr_pkg::CFG_DELAY, 20'd0);
    write_reg(tsdr_pkg::CFG_KEEP, 20'd1);
    quiet = 1;
    random_phase(200, 3);
    wait_idle();
    quiet = 0;

    write_reg(tsdr_pkg::CFG_DELAY, 20'hFFFFF);
    write_reg(tsdr_pkg::CFG_KEEP, 20'hFFFFF);
    clock_us = 32'hFFF0_0000;
    random_phase(250, 60000);
    wait_idle();

    write_reg(tsdr_pkg::CFG_DELAY, 20'd3000);
    write_reg(tsdr_pkg::CFG_KEEP, 20'd8000);
    clock_us = $urandom;
    random_phase(250, 500);
    wait_idle();

    write_reg(tsdr_pkg::CFG_DELAY, 20'd20000);
    write_reg(tsdr_pkg::CFG_KEEP, 20'hFFFFF);
    random_phase(250, 800);
    wait_idle();

    write_reg(tsdr_pkg::CFG_DELAY, 20'd100);
    write_reg(tsdr_pkg::CFG_KEEP, 20'd300);
    random_phase(250, 50);
    wait_idle();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
